[rtl/core/dcrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrt_pkg: shared constants of the centroid ROI tracker
// Field widths, configuration register map, reset values and trust limits.
// ----------------------------------------------------------------------------
package dcrt_pkg;

    localparam int COORD_W    = 10;
    localparam int CONF_W     = 9;
    localparam int TRUST_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // configuration register map
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONF     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

    // register reset values
    localparam logic [CONF_W-1:0]  MIN_CONF_RST     = 9'd77;
    localparam logic [COORD_W-1:0] ROI_WIDTH_RST    = 10'd160;
    localparam logic [COORD_W-1:0] ROI_HEIGHT_RST   = 10'd120;
    localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = 10'd320;
    localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 10'd240;
    localparam logic [COORD_W-1:0] REGION_LEFT_RST  = 10'd80;
    localparam logic [COORD_W-1:0] REGION_TOP_RST   = 10'd60;

    localparam logic [TRUST_W-1:0] TRUST_MAX       = 4'd10;
    localparam logic [TRUST_W-1:0] TRUST_USE_ABOVE = 4'd3;
    localparam int                 MIN_POINTS      = 3;

endpackage

[rtl/core/detection_centroid_roi_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_centroid_roi_tracker: recentres a region of interest on detections
// Keeps a sliding point history with running sums; every UPDATE_PERIOD-th
// accepted detection, once MIN_POINTS are held, moves the region onto the floored mean.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat carries det_x, det_y and
//   confidence. Output channel (out_valid/out_ready): exactly one result beat
//   per input beat, in order. Config channel (cfg_valid/cfg_ready, always
//   ready): cfg_index selects min_confidence, roi_width, roi_height,
//   frame_width, frame_height; other indexes are dropped. Write config only
//   while the block is idle.
//   Timing: one item at a time. A rejected detection goes from accept to the
//   done state; an accepted one passes the sum state first. An item that
//   recentres the region also passes the divide and place states, the divide
//   state lasting as long as the two bit-serial dividers that compute the x
//   and y means one quotient bit per cycle. The history read of the oldest
//   point overlaps the accept cycle.
//   The result register frees the input side: a new beat is taken while the
//   previous result still waits. If out_ready stays low, the next result
//   holds in its final state and in_ready stays low until the slot frees.
//   Reset restores the control and configuration registers to their defaults,
//   empties the history and disables the region; no clearing pass runs.
// ----------------------------------------------------------------------------
module detection_centroid_roi_tracker #(
    parameter int HISTORY_DEPTH = 50,
    parameter int UPDATE_PERIOD = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input beat
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dcrt_pkg::COORD_W-1:0]      det_x,
    input  logic [dcrt_pkg::COORD_W-1:0]      det_y,
    input  logic [dcrt_pkg::CONF_W-1:0]       confidence,
    // result beat
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              accepted,
    output logic                              roi_updated,
    output logic [dcrt_pkg::COORD_W-1:0]      roi_left,
    output logic [dcrt_pkg::COORD_W-1:0]      roi_top,
    output logic                              roi_enabled,
    output logic [dcrt_pkg::TRUST_W-1:0]      roi_trust_tenths,
    output logic                              use_roi,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dcrt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dcrt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import dcrt_pkg::*;

    localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W   = COORD_W + CNT_W;
    localparam int PHASE_W = (UPDATE_PERIOD > 1) ? $clog2(UPDATE_PERIOD) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SUM   = 5'b00010,
        S_DIV   = 5'b00100,
        S_PLACE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    // Center an edge on the mean, then clamp at zero and at the frame edge.
    function automatic logic [COORD_W-1:0] place_edge(
        input logic [COORD_W-1:0] mean,
        input logic [COORD_W-1:0] size,
        input logic [COORD_W-1:0] frame
    );
        logic [COORD_W-1:0] half;
        logic [COORD_W-1:0] edge_v;
        logic [COORD_W:0]   reach;
        half   = size >> 1;
        edge_v = (mean > half) ? (mean - half) : '0;
        reach  = {1'b0, edge_v} + {1'b0, size};
        if (reach > {1'b0, frame})
        begin
            edge_v = (frame >= size) ? (frame - size) : '0;
        end
        return edge_v;
    endfunction

    // control and state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SUM_W-1:0]   sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]   sum_y_reg, sum_y_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [COORD_W-1:0] left_reg, left_next;
    logic [COORD_W-1:0] top_reg, top_next;
    logic               on_reg, on_next;
    logic [TRUST_W-1:0] trust_reg, trust_next;
    logic               acc_reg, acc_next;
    logic               upd_reg, upd_next;
    logic               out_valid_reg, out_valid_next;

    // configuration registers
    logic [CONF_W-1:0]  min_conf_reg;
    logic [COORD_W-1:0] roi_w_reg;
    logic [COORD_W-1:0] roi_h_reg;
    logic [COORD_W-1:0] frame_w_reg;
    logic [COORD_W-1:0] frame_h_reg;

    // payload
    logic [COORD_W-1:0] px_reg;
    logic [COORD_W-1:0] py_reg;
    logic               o_acc_reg;
    logic               o_upd_reg;
    logic [COORD_W-1:0] o_left_reg;
    logic [COORD_W-1:0] o_top_reg;
    logic               o_on_reg;
    logic [TRUST_W-1:0] o_trust_reg;
    logic               o_use_reg;

    logic                   in_fire;
    logic                   out_load;
    logic                   full;
    logic                   period_hit;
    logic                   launch;
    logic                   div_start;
    logic [2*COORD_W-1:0]   hist_rdata;
    logic [COORD_W-1:0]     old_x;
    logic [COORD_W-1:0]     old_y;
    logic                   div_x_done;
    logic                   div_y_done;
    logic [SUM_W-1:0]       mean_x;
    logic [SUM_W-1:0]       mean_y;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign old_x = hist_rdata[2*COORD_W-1:COORD_W];
    assign old_y = hist_rdata[COORD_W-1:0];
    assign full  = (cnt_reg == CNT_W'(HISTORY_DEPTH));

    // Point history: the read of the slot about to be overwritten is issued
    // at accept time so the old point is ready in the sum cycle.
    dcrt_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (state_reg == S_SUM),
        .waddr (slot_reg),
        .wdata ({px_reg, py_reg}),
        .re    (in_fire),
        .raddr (slot_reg),
        .rdata (hist_rdata)
    );

    // Two divider lanes run in lockstep, one for each axis.
    dcrt_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_x_next),
        .divisor  (cnt_next),
        .done     (div_x_done),
        .quotient (mean_x)
    );

    dcrt_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_y_next),
        .divisor  (cnt_next),
        .done     (div_y_done),
        .quotient (mean_y)
    );

    // History bookkeeping for the sum cycle: replace the oldest point once
    // the history is full, otherwise grow it.
    always_comb
    begin
        cnt_next   = full ? cnt_reg : (cnt_reg + CNT_W'(1));
        sum_x_next = sum_x_reg - (full ? SUM_W'(old_x) : '0) + SUM_W'(px_reg);
        sum_y_next = sum_y_reg - (full ? SUM_W'(old_y) : '0) + SUM_W'(py_reg);
        slot_next  = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                                               : (slot_reg + SLOT_W'(1));
        period_hit = (phase_reg == PHASE_W'(UPDATE_PERIOD - 1));
        phase_next = period_hit ? '0 : (phase_reg + PHASE_W'(1));
        launch     = period_hit && (cnt_next >= CNT_W'(MIN_POINTS));
        div_start  = (state_reg == S_SUM) && launch;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        upd_next       = upd_reg;
        left_next      = left_reg;
        top_next       = top_reg;
        on_next        = on_reg;
        trust_next     = trust_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    acc_next   = (confidence >= min_conf_reg);
                    upd_next   = 1'b0;
                    state_next = (confidence >= min_conf_reg) ? S_SUM : S_DONE;
                end
            end
            S_SUM:
            begin
                state_next = launch ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (div_x_done && div_y_done)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                left_next  = place_edge(mean_x[COORD_W-1:0], roi_w_reg, frame_w_reg);
                top_next   = place_edge(mean_y[COORD_W-1:0], roi_h_reg, frame_h_reg);
                on_next    = 1'b1;
                trust_next = (trust_reg < TRUST_MAX) ? (trust_reg + TRUST_W'(1)) : trust_reg;
                upd_next   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            slot_reg      <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            phase_reg     <= '0;
            left_reg      <= REGION_LEFT_RST;
            top_reg       <= REGION_TOP_RST;
            on_reg        <= 1'b0;
            trust_reg     <= '0;
            acc_reg       <= 1'b0;
            upd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            top_reg       <= top_next;
            on_reg        <= on_next;
            trust_reg     <= trust_next;
            acc_reg       <= acc_next;
            upd_reg       <= upd_next;
            out_valid_reg <= out_valid_next;
            // commit the history update in the sum cycle
            if (state_reg == S_SUM)
            begin
                cnt_reg   <= cnt_next;
                slot_reg  <= slot_next;
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
                phase_reg <= phase_next;
            end
        end
    end

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_conf_reg <= MIN_CONF_RST;
            roi_w_reg    <= ROI_WIDTH_RST;
            roi_h_reg    <= ROI_HEIGHT_RST;
            frame_w_reg  <= FRAME_WIDTH_RST;
            frame_h_reg  <= FRAME_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MIN_CONF:     min_conf_reg <= cfg_data[CONF_W-1:0];
                CFG_ROI_WIDTH:    roi_w_reg    <= cfg_data[COORD_W-1:0];
                CFG_ROI_HEIGHT:   roi_h_reg    <= cfg_data[COORD_W-1:0];
                CFG_FRAME_WIDTH:  frame_w_reg  <= cfg_data[COORD_W-1:0];
                CFG_FRAME_HEIGHT: frame_h_reg  <= cfg_data[COORD_W-1:0];
                default:          ;
            endcase
        end
    end

    // Payload: latch the point on accept, snapshot the result on load.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            px_reg <= det_x;
            py_reg <= det_y;
        end
        if (out_load)
        begin
            o_acc_reg   <= acc_reg;
            o_upd_reg   <= upd_reg;
            o_left_reg  <= left_reg;
            o_top_reg   <= top_reg;
            o_on_reg    <= on_reg;
            o_trust_reg <= trust_reg;
            o_use_reg   <= on_reg && (trust_reg > TRUST_USE_ABOVE);
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = o_acc_reg;
    assign roi_updated      = o_upd_reg;
    assign roi_left         = o_left_reg;
    assign roi_top          = o_top_reg;
    assign roi_enabled      = o_on_reg;
    assign roi_trust_tenths = o_trust_reg;
    assign use_roi          = o_use_reg;

`ifndef SYNTHESIS
    // trust saturates at ten tenths
    a_trust_sat: assert property (@(posedge clk) disable iff (!rst_n)
        trust_reg <= TRUST_MAX)
        else $error("region trust above saturation limit");

    // history bookkeeping stays inside the store
    a_hist_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= CNT_W'(HISTORY_DEPTH)) && (slot_reg <= SLOT_W'(HISTORY_DEPTH - 1)))
        else $error("history count or write slot out of range");

    // both divider lanes finish together, and only while the sequencer waits
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (div_x_done == div_y_done) && (!div_x_done || (state_reg == S_DIV)))
        else $error("divider lanes out of step with sequencer");

    // a recentre is only reported for an accepted detection
    a_upd_implies_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLACE) |=> (state_reg == S_DONE) && upd_reg && acc_reg)
        else $error("region recentred without accepted detection");
`endif

endmodule

[rtl/core/dcrt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module dcrt_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 50
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/dcrt_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrt_div: bit-serial restoring divider
// Shifts the dividend out one bit per cycle and the quotient in; DVD_W steps.
// ----------------------------------------------------------------------------
module dcrt_div #(
    parameter int DVD_W = 16,
    parameter int DVS_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              fits;
    logic              last_step;

    assign trial     = {rem_reg, quo_reg[DVD_W-1]};
    assign diff      = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});
    assign last_step = busy_reg && (step_reg == STEP_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // shift one dividend bit in, one quotient bit out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[tb/tb_detection_centroid_roi_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_detection_centroid_roi_tracker: self-checking bench for the ROI tracker
// Drives detections and register writes over valid/ready channels, predicts
// each result beat from a cycle-free model of the history, running sums and
// region update, and compares every result beat field by field in order.
// ----------------------------------------------------------------------------
module tb_detection_centroid_roi_tracker;

    import dcrt_pkg::*;

    localparam int HISTORY_DEPTH  = 50;
    localparam int UPDATE_PERIOD  = 5;
    localparam int PHASES         = 12;
    localparam int HITS_PER_PHASE = 130;   // accepted detections per phase
    localparam int STALL_LIMIT    = 5000;  // cycles without any beat
    localparam int TAIL_CYCLES    = 64;    // > longest recentre latency

    // first register index outside the map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNMAPPED = CFG_IDX_W'(CFG_FRAME_HEIGHT + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX     = '1;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CONF_W-1:0]  c;
    } detection_t;

    typedef struct packed {
        logic               accepted;
        logic               updated;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic               enabled;
        logic [TRUST_W-1:0] trust;
        logic               use_roi;
    } roi_report_t;

    // ------------------------------------------------------------------------
    // Tracker scoreboard: own copy of registers, point history and region.
    // take_detection predicts one result beat per input beat, accepted or not;
    // match_report pops the oldest prediction and compares it.
    // ------------------------------------------------------------------------
    class roi_track_board;
        logic [CONF_W-1:0]  min_conf;
        logic [COORD_W-1:0] roi_w, roi_h, frame_w, frame_h;
        logic [COORD_W-1:0] x_hist [HISTORY_DEPTH];
        logic [COORD_W-1:0] y_hist [HISTORY_DEPTH];
        int unsigned        held, slot, phase, sum_x, sum_y;
        logic [COORD_W-1:0] left, top;
        bit                 on;
        logic [TRUST_W-1:0] trust;
        roi_report_t        reports_due[$];
        int unsigned        mismatches;

        function new();
            min_conf = MIN_CONF_RST;
            roi_w    = ROI_WIDTH_RST;
            roi_h    = ROI_HEIGHT_RST;
            frame_w  = FRAME_WIDTH_RST;
            frame_h  = FRAME_HEIGHT_RST;
            foreach (x_hist[i])
            begin
                x_hist[i] = '0;
                y_hist[i] = '0;
            end
            held       = 0;
            slot       = 0;
            phase      = 0;
            sum_x      = 0;
            sum_y      = 0;
            left       = REGION_LEFT_RST;
            top        = REGION_TOP_RST;
            on         = 1'b0;
            trust      = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MIN_CONF:     min_conf = data[CONF_W-1:0];
                CFG_ROI_WIDTH:    roi_w    = data[COORD_W-1:0];
                CFG_ROI_HEIGHT:   roi_h    = data[COORD_W-1:0];
                CFG_FRAME_WIDTH:  frame_w  = data[COORD_W-1:0];
                CFG_FRAME_HEIGHT: frame_h  = data[COORD_W-1:0];
                default: ;
            endcase
        endfunction

        // center a span of 'size' on 'mean', then pull it back inside the frame
        function logic [COORD_W-1:0] fit_edge(int unsigned mean, int unsigned size,
                                              int unsigned frame);
            int unsigned half, pos;
            half = size / 2;
            pos  = (mean > half) ? mean - half : 0;
            if (pos + size > frame)
                pos = (frame >= size) ? frame - size : 0;
            return COORD_W'(pos);
        endfunction

        function void take_detection(detection_t d);
            roi_report_t r;
            r = '0;
            if (d.c >= min_conf)
            begin
                r.accepted = 1'b1;
                // full history: retire the oldest point from the sums
                if (held >= HISTORY_DEPTH)
                begin
                    sum_x -= x_hist[slot];
                    sum_y -= y_hist[slot];
                end
                else
                begin
                    held++;
                end
                x_hist[slot] = d.x;
                y_hist[slot] = d.y;
                sum_x += d.x;
                sum_y += d.y;
                slot = (slot + 1 >= HISTORY_DEPTH) ? 0 : slot + 1;
                phase++;
                if (phase >= UPDATE_PERIOD)
                begin
                    phase = 0;
                    if (held >= MIN_POINTS)
                    begin
                        left = fit_edge(sum_x / held, roi_w, frame_w);
                        top  = fit_edge(sum_y / held, roi_h, frame_h);
                        if (trust < TRUST_MAX)
                            trust++;
                        on        = 1'b1;
                        r.updated = 1'b1;
                    end
                end
            end
            r.left    = left;
            r.top     = top;
            r.enabled = on;
            r.trust   = trust;
            r.use_roi = on && (trust > TRUST_USE_ABOVE);
            reports_due.insert(reports_due.size(), r);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void match_report(roi_report_t got);
            roi_report_t want;
            if (reports_due.size() == 0)
            begin
                $display("%0t ns: result beat with no detection outstanding, %s %h",
                         $time, "expected none, actual", got);
                mismatches++;
                return;
            end
            want = reports_due.pop_front();
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("roi_updated", want.updated, got.updated);
            compare_field("roi_left", want.left, got.left);
            compare_field("roi_top", want.top, got.top);
            compare_field("roi_enabled", want.enabled, got.enabled);
            compare_field("roi_trust_tenths", want.trust, got.trust);
            compare_field("use_roi", want.use_roi, got.use_roi);
        endfunction

        function int pending();
            return reports_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [COORD_W-1:0]    det_x;
    logic [COORD_W-1:0]    det_y;
    logic [CONF_W-1:0]     confidence;
    logic                  out_valid;
    logic                  out_ready;
    logic                  accepted;
    logic                  roi_updated;
    logic [COORD_W-1:0]    roi_left;
    logic [COORD_W-1:0]    roi_top;
    logic                  roi_enabled;
    logic [TRUST_W-1:0]    roi_trust_tenths;
    logic                  use_roi;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    detection_centroid_roi_tracker #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .UPDATE_PERIOD (UPDATE_PERIOD)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .det_x            (det_x),
        .det_y            (det_y),
        .confidence       (confidence),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .accepted         (accepted),
        .roi_updated      (roi_updated),
        .roi_left         (roi_left),
        .roi_top          (roi_top),
        .roi_enabled      (roi_enabled),
        .roi_trust_tenths (roi_trust_tenths),
        .use_roi          (use_roi),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #1 clk = ~clk;

    roi_track_board sb = new();

    // idling odds: 0 means no idling, N means roughly one burst every N beats
    int gap_odds  = 0;
    int sink_odds = 0;

    // cluster center that well-formed tracks jitter around
    int track_x = 160;
    int track_y = 120;

    int quiet_cycles = 0;

    // Opening set at reset registers (threshold 77): both sides of the
    // threshold, coordinate and confidence extremes, alternating bit patterns.
    // The fifth and tenth accepted points recentre the region; the first one
    // lands past the right and bottom edges and gets clamped back.
    detection_t opening [16] = '{
        '{10'd0,    10'd0,    9'd0},
        '{10'd1023, 10'd1023, 9'd76},
        '{10'd1023, 10'd1023, 9'd77},
        '{10'd0,    10'd0,    9'd256},
        '{10'd1023, 10'd0,    9'd511},
        '{10'd0,    10'd1023, 9'd300},
        '{10'd512,  10'd512,  9'd128},
        '{10'h155,  10'h2AA,  9'h155},
        '{10'h2AA,  10'h155,  9'h0AA},
        '{10'd1,    10'd1,    9'd1},
        '{10'd5,    10'd3,    9'd255},
        '{10'd2,    10'd7,    9'd257},
        '{10'd0,    10'd0,    9'd77},
        '{10'd1023, 10'd1023, 9'd200},
        '{10'd300,  10'd200,  9'd76},
        '{10'd10,   10'd20,   9'd100}
    };

    // ------------------------------------------------------------------------
    // Result side: random stall bursts on out_ready, steady when sink_odds is 0
    // ------------------------------------------------------------------------
    initial
    begin : sink
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (sink_odds != 0 && $urandom_range(1, sink_odds) == 1)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // check every result beat against the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        roi_report_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{accepted, roi_updated, roi_left, roi_top,
                    roi_enabled, roi_trust_tenths, use_roi};
            sb.match_report(got);
        end
    end

    // watchdog: give up when no channel moves a beat for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Drivers. send_detection and write_reg start at a rising-edge step and return
    // at the step of their handshake with valid still high; the caller drops valid.
    // ------------------------------------------------------------------------
    task automatic send_detection(input detection_t d);
        in_valid   <= 1'b1;
        det_x      <= d.x;
        det_y      <= d.y;
        confidence <= d.c;
        do @(posedge clk); while (!in_ready);
        sb.take_detection(d);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // write the whole map plus one unmapped index, which must change nothing
    task automatic program_regs(input logic [CFG_DATA_W-1:0] thresh, rw, rh, fw, fh);
        write_reg(CFG_MIN_CONF, thresh);
        write_reg(CFG_ROI_WIDTH, rw);
        write_reg(CFG_ROI_HEIGHT, rh);
        write_reg(CFG_FRAME_WIDTH, fw);
        write_reg(CFG_FRAME_HEIGHT, fh);
        write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNMAPPED, CFG_LAST_INDEX)),
                  CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // hold until every predicted result has come back; always steps past a rising edge
    task automatic settle();
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Mostly points jittered around a slowly jumping center, so the mean
    // and clamps see realistic tracks; some fully random points toggle every
    // coordinate bit. Unless the threshold is zero, about one in five falls under it.
    function automatic detection_t next_detection();
        detection_t d;
        int jx, jy;
        if ($urandom_range(0, 29) == 0)
        begin
            track_x = $urandom_range(0, 1023);
            track_y = $urandom_range(0, 1023);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            d.x = COORD_W'($urandom_range(0, 1023));
            d.y = COORD_W'($urandom_range(0, 1023));
        end
        else
        begin
            jx = track_x + int'($urandom_range(0, 48)) - 24;
            jy = track_y + int'($urandom_range(0, 48)) - 24;
            d.x = COORD_W'((jx < 0) ? 0 : (jx > 1023) ? 1023 : jx);
            d.y = COORD_W'((jy < 0) ? 0 : (jy > 1023) ? 1023 : jy);
        end
        if (sb.min_conf != 0 && $urandom_range(0, 4) == 0)
            d.c = CONF_W'($urandom_range(0, int'(sb.min_conf) - 1));
        else
            d.c = CONF_W'($urandom_range(int'(sb.min_conf), 511));
        return d;
    endfunction

    // send detections until want_hits of them pass the threshold
    task automatic run_phase(input int want_hits);
        detection_t d;
        int hits;
        bit gap, drain;
        hits = 0;
        while (hits < want_hits)
        begin
            d = next_detection();
            if (d.c >= sb.min_conf)
                hits++;
            send_detection(d);
            gap   = gap_odds != 0 && $urandom_range(1, gap_odds) == 1;
            drain = gap_odds != 0 && $urandom_range(0, 63) == 0;
            if (gap || drain)
            begin
                in_valid <= 1'b0;
                // drain: pause until the pipeline has handed back everything
                if (drain)
                    settle();
                if (gap)
                    repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        det_x      = '0;
        det_y      = '0;
        confidence = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening at reset register values, back to back
        foreach (opening[i])
            send_detection(opening[i]);
        in_valid <= 1'b0;
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                // no threshold, region as big as the frame
                0: program_regs(10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
                // only full confidence and above, one-pixel region and frame
                1: program_regs(10'd256, 10'd1, 10'd1, 10'd1, 10'd1);
                // threshold at the 9-bit top, zero region and frame sizes
                2: program_regs(10'd1023, 10'd0, 10'd0, 10'd0, 10'd0);
                // region wider and taller than the frame: both edges clamp to 0
                3: program_regs(10'd77, 10'd600, 10'd300, 10'd320, 10'd240);
                4: program_regs(CFG_DATA_W'(MIN_CONF_RST), CFG_DATA_W'(ROI_WIDTH_RST),
                                CFG_DATA_W'(ROI_HEIGHT_RST), CFG_DATA_W'(FRAME_WIDTH_RST),
                                CFG_DATA_W'(FRAME_HEIGHT_RST));
                default: program_regs(
                    ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 1023))
                                                : CFG_DATA_W'($urandom_range(0, 256)),
                    CFG_DATA_W'($urandom_range(0, 1023)),
                    CFG_DATA_W'($urandom_range(0, 1023)),
                    CFG_DATA_W'($urandom_range(0, 1023)),
                    CFG_DATA_W'($urandom_range(0, 1023)));
            endcase
            // last phase runs flat out on both sides
            if (p == PHASES - 1)
            begin
                gap_odds  = 0;
                sink_odds = 0;
            end
            else
            begin
                gap_odds  = 3 * $urandom_range(0, 2);
                sink_odds = 3 * $urandom_range(0, 2);
            end
            run_phase(HITS_PER_PHASE);
            settle();
        end

        // let any stray result beat surface before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
